>>> rtl/core/bba_pkg.sv
// Shared constants, status codes and controller/datapath link types of the block allocator.
package bba_pkg;

  // Field widths of the request and response channels.
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned STATUS_W = 2;

  // Running block base; one bit wider than a block index so it can pass the limit.
  localparam int unsigned BASE_W = 13;

  // Blocks at or above this index are never handed out.
  localparam logic [BASE_W-1:0] INDEX_LIMIT = 13'd4096;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED = 2'd2;

  // Request mode codes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Word 0 after reset: superblock and map blocks in use.
  localparam logic [7:0] RESET_WORD0 = 8'h03;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // write one initial word during the clearing pass
    logic start;      // latch the request and rewind the word pointer
    logic issue;      // read the word at the pointer and advance
    logic seek_step;  // advance the pointer without reading
    logic wr_alloc;   // set the found bit and record the allocated block
    logic wr_free;    // clear the bit of the requested block
    logic set_full;   // record a map-full response
    logic set_freed;  // record a freed response
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ptr_last;   // pointer stands on the last map word
    logic scan_more;  // pointer still inside the scanned range
    logic hit;        // read word holds a usable clear bit
    logic data_last;  // read word is the last one scanned
    logic seek_done;  // requested block lies in the word at the pointer
  } dp_stat_t;

endpackage

>>> rtl/core/bba_if.sv
// Request and response channel interfaces of the block allocator.
interface bba_req_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [INDEX_W-1:0] block_index;

  modport source (output valid, output mode, output block_index, input ready);
  modport sink (input valid, input mode, input block_index, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  result_block;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output result_block, output status, input ready);
  modport sink (input valid, input result_block, input status, output ready);
endinterface

>>> rtl/core/bba_dp.sv
// Datapath of the block allocator: map memory, word pointer, bit search and result registers.
module bba_dp import bba_pkg::*; #(
  parameter int unsigned MAP_WORDS = 128,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic                req_mode_i,
  input  logic [INDEX_W-1:0]  req_index_i,
  output logic [INDEX_W-1:0]  result_block_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PW    = $clog2(MAP_WORDS + 1);
  localparam int unsigned BIT_W = $clog2(WORD_BITS);
  localparam int unsigned WORDS_IN_RANGE =
    (int'(INDEX_LIMIT) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned SCAN_WORDS =
    (MAP_WORDS < WORDS_IN_RANGE) ? MAP_WORDS : WORDS_IN_RANGE;
  localparam logic [BASE_W-1:0] WB_STEP = BASE_W'(WORD_BITS);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  logic [PW-1:0]        ptr_q, ptr_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic                 rdv_q;
  logic [AW-1:0]        data_ptr_q;
  logic [BASE_W-1:0]    data_base_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mode_q;
  logic [INDEX_W-1:0]   index_q;
  logic [INDEX_W-1:0]   result_block_q;
  logic [STATUS_W-1:0]  status_q;

  logic [WORD_BITS-1:0] masked;
  logic                 found;
  logic [BIT_W-1:0]     hit_bit;
  logic [BASE_W-1:0]    alloc_blk;
  logic [BASE_W-1:0]    free_off;
  logic [BIT_W-1:0]     free_bit;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Pointer and base: rewind on a new request, step on a read or a seek; a clearing write steps the pointer only.
  always_comb begin
    ptr_d  = ptr_q;
    base_d = base_q;
    if (cmd_i.start) begin
      ptr_d  = '0;
      base_d = '0;
    end else if (cmd_i.clr_step) begin
      ptr_d = ptr_q + PW'(1);
    end else if (cmd_i.issue || cmd_i.seek_step) begin
      ptr_d  = ptr_q + PW'(1);
      base_d = base_q + WB_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      rdv_q <= cmd_i.issue;
    end
  end

  // Request and read-side payload registers.
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    if (cmd_i.start) begin
      mode_q  <= req_mode_i;
      index_q <= req_index_i;
    end
    if (cmd_i.issue) begin
      data_ptr_q  <= ptr_q[AW-1:0];
      data_base_q <= base_q;
    end
  end

  // Blocks past the index limit count as used; then find the lowest clear bit.
  always_comb begin
    masked  = rdata_q;
    found   = 1'b0;
    hit_bit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (data_base_q + BASE_W'(b) >= INDEX_LIMIT) begin
        masked[b] = 1'b1;
      end
    end
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!masked[b]) begin
        found   = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign alloc_blk = data_base_q + BASE_W'(hit_bit);
  assign free_off  = {1'b0, index_q} - data_base_q;
  assign free_bit  = free_off[BIT_W-1:0];

  // Memory write port: clearing pass, allocation set, or free clear.
  always_comb begin
    mem_we    = cmd_i.clr_step || cmd_i.wr_alloc || cmd_i.wr_free;
    mem_waddr = data_ptr_q;
    mem_wdata = rdata_q;
    if (cmd_i.clr_step) begin
      mem_waddr = ptr_q[AW-1:0];
      mem_wdata = (ptr_q == '0) ? WORD_BITS'(RESET_WORD0) : '0;
    end else if (cmd_i.wr_alloc) begin
      mem_wdata = rdata_q | (WORD_BITS'(1) << hit_bit);
    end else if (cmd_i.wr_free) begin
      mem_wdata = rdata_q & ~(WORD_BITS'(1) << free_bit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[ptr_q[AW-1:0]];
    end
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_alloc) begin
      result_block_q <= alloc_blk[INDEX_W-1:0];
      status_q       <= ST_ALLOC;
    end else if (cmd_i.set_full) begin
      result_block_q <= '0;
      status_q       <= ST_FULL;
    end else if (cmd_i.set_freed) begin
      result_block_q <= '0;
      status_q       <= (mode_q == MODE_FREE) ? ST_FREED : ST_FULL;
    end
  end

  // Status towards the controller.
  always_comb begin
    stat_o.ptr_last  = (ptr_q == PW'(MAP_WORDS - 1));
    stat_o.scan_more = (ptr_q < PW'(SCAN_WORDS));
    stat_o.hit       = rdv_q && found;
    stat_o.data_last = rdv_q && (data_ptr_q == AW'(SCAN_WORDS - 1));
    stat_o.seek_done = ({1'b0, index_q} < (base_q + WB_STEP));
  end

  assign result_block_o = result_block_q;
  assign status_o       = status_q;

endmodule

>>> rtl/core/bba_ctrl.sv
// Controller of the block allocator: clearing pass, scan and free sequencing, handshakes.
module bba_ctrl import bba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SEEK,
    S_FREE_WR,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   valid_q, valid_d;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    valid_d = valid_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = S_IDLE;
          ready_d = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.start = 1'b1;
          ready_d     = 1'b0;
          state_d     = (in_mode_i == MODE_FREE) ? S_SEEK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.wr_alloc = 1'b1;
          valid_d        = 1'b1;
          state_d        = S_RESP;
        end else if (stat_i.data_last) begin
          cmd_o.set_full = 1'b1;
          valid_d        = 1'b1;
          state_d        = S_RESP;
        end else if (stat_i.scan_more) begin
          cmd_o.issue = 1'b1;
        end
      end
      S_SEEK: begin
        if (stat_i.seek_done) begin
          cmd_o.issue = 1'b1;
          state_d     = S_FREE_WR;
        end else if (stat_i.ptr_last) begin
          // The block lies past the map: answer without touching it.
          cmd_o.set_freed = 1'b1;
          valid_d         = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.seek_step = 1'b1;
        end
      end
      S_FREE_WR: begin
        cmd_o.wr_free   = 1'b1;
        cmd_o.set_freed = 1'b1;
        valid_d         = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) begin
          valid_d = 1'b0;
          ready_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
        ready_d = 1'b1;
        valid_d = 1'b0;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ready_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;

endmodule

>>> rtl/core/bitmap_block_allocator_core.sv
// Top level of the bitmap first-fit block allocator.
//
// Requests arrive on req_i (mode, block_index) and each one gives exactly one
// response on rsp_o (result_block, status). Mode allocate scans the free map
// from word 0 upward, one word per cycle through the map memory's registered
// read port, and takes the lowest clear bit of the first usable word. Mode
// free clears the bit of block_index; finding its word steps the word pointer
// once per cycle, so no divider is needed.
// One request is in progress at a time; a new one is taken only after the
// response of the last one has been accepted. After reset the block runs a
// clearing pass, writing word 0 to three and every other word to zero;
// req_i.ready stays low meanwhile. A response is held in its register until
// rsp_o.ready is seen; while the receiver stalls, no new request is taken.
module bitmap_block_allocator_core import bba_pkg::*; #(
  parameter int unsigned MAP_WORDS = 128,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bba_req_if.sink          req_i,
  bba_rsp_if.source        rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing.
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_mode_i   (req_i.mode),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Map storage and search.
  bba_dp #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_mode_i     (req_i.mode),
    .req_index_i    (req_i.block_index),
    .result_block_o (rsp_o.result_block),
    .status_o       (rsp_o.status)
  );

  // No request is taken while a response waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("request ready while a response is pending");

  // Only an allocation carries a non-zero block index.
  a_zero_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_ALLOC) |-> rsp_o.result_block == '0)
    else $error("non-zero block on a full or freed response");

  // An accepted request closes the request channel until its response is done.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request channel stayed open after an accept");

endmodule

>>> dv/tb.sv
// Self-checking testbench of the bitmap block allocator core with a free map predictor.
module tb import bba_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_WORDS     = 128;
  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned FILL_ITEMS    = 100;
  localparam int unsigned PHASE_ITEMS   = 90;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned N_DIRECTED    = 23;

  // One response as the block should return it.
  typedef struct {
    logic [INDEX_W-1:0]  result_block;
    logic [STATUS_W-1:0] status;
  } rsp_item_t;

  // One row of the directed table; typed rows carry their response.
  typedef struct {
    logic                mode;
    logic [INDEX_W-1:0]  block_index;
    bit                  typed;
    logic [INDEX_W-1:0]  result_block;
    logic [STATUS_W-1:0] status;
  } directed_row_t;

  logic clk;
  logic rst_ni;

  bba_req_if req_bus ();
  bba_rsp_if rsp_bus ();

  bitmap_block_allocator_core #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the usage map and the responses still owed by the block.
  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  rsp_item_t            owed_responses [$];
  int unsigned          mismatches = 0;
  int unsigned          send_gap_pct = 0;
  int unsigned          rsp_stall_pct = 0;
  bit                   hold_off_pending = 1'b0;
  int unsigned          quiet_cycles = 0;

  // Directed requests: reserved blocks, index extremes, repeated frees, word edges.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{MODE_ALLOC, 12'h000, 1'b1, 12'd2,  ST_ALLOC},
    '{MODE_ALLOC, 12'h000, 1'b1, 12'd3,  ST_ALLOC},
    '{MODE_FREE,  12'h000, 1'b1, 12'd0,  ST_FREED},
    '{MODE_ALLOC, 12'hfff, 1'b1, 12'd0,  ST_ALLOC},
    '{MODE_FREE,  12'h001, 1'b1, 12'd0,  ST_FREED},
    '{MODE_ALLOC, 12'h000, 1'b1, 12'd1,  ST_ALLOC},
    '{MODE_FREE,  12'hfff, 1'b1, 12'd0,  ST_FREED},
    '{MODE_FREE,  12'hfff, 1'b1, 12'd0,  ST_FREED},
    '{MODE_FREE,  12'h000, 1'b1, 12'd0,  ST_FREED},
    '{MODE_FREE,  12'h001, 1'b1, 12'd0,  ST_FREED},
    '{MODE_ALLOC, 12'h000, 1'b1, 12'd0,  ST_ALLOC},
    '{MODE_ALLOC, 12'h000, 1'b1, 12'd1,  ST_ALLOC},
    '{MODE_ALLOC, 12'h000, 1'b1, 12'd4,  ST_ALLOC},
    '{MODE_FREE,  12'h003, 1'b1, 12'd0,  ST_FREED},
    '{MODE_ALLOC, 12'h000, 1'b1, 12'd3,  ST_ALLOC},
    '{MODE_FREE,  12'haaa, 1'b0, 12'd0,  ST_ALLOC},
    '{MODE_FREE,  12'h555, 1'b0, 12'd0,  ST_ALLOC},
    '{MODE_FREE,  12'h020, 1'b0, 12'd0,  ST_ALLOC},
    '{MODE_FREE,  12'h01f, 1'b1, 12'd0,  ST_FREED},
    '{MODE_ALLOC, 12'h7ff, 1'b0, 12'd0,  ST_ALLOC},
    '{MODE_FREE,  12'h002, 1'b0, 12'd0,  ST_ALLOC},
    '{MODE_ALLOC, 12'h800, 1'b0, 12'd0,  ST_ALLOC},
    '{MODE_FREE,  12'hfff, 1'b1, 12'd0,  ST_FREED}
  };

  // Applies one request to the shadow map and returns the response it earns.
  function automatic rsp_item_t apply_request(input logic mode,
                                              input logic [INDEX_W-1:0] block_index);
    rsp_item_t   rsp;
    int unsigned word_sel;
    int unsigned bit_sel;
    rsp.result_block = '0;
    rsp.status       = ST_FULL;
    if (mode == MODE_FREE) begin
      word_sel = block_index / WORD_BITS;
      bit_sel  = block_index % WORD_BITS;
      if (word_sel < MAP_WORDS) begin
        shadow_map[word_sel][bit_sel] = 1'b0;
      end
      rsp.status = ST_FREED;
      return rsp;
    end
    // First word with a clear bit, then its lowest clear bit below the index limit.
    for (int unsigned w = 0; w < MAP_WORDS; w++) begin
      if (&shadow_map[w]) continue;
      for (int unsigned b = 0; b < WORD_BITS; b++) begin
        if (w * WORD_BITS + b >= INDEX_LIMIT) break;
        if (!shadow_map[w][b]) begin
          shadow_map[w][b] = 1'b1;
          rsp.result_block = INDEX_W'(w * WORD_BITS + b);
          rsp.status       = ST_ALLOC;
          return rsp;
        end
      end
    end
    return rsp;
  endfunction

  // Clock generator.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offers one request after a random gap and records its response once accepted.
  task automatic send_request(input logic mode, input logic [INDEX_W-1:0] block_index,
                              input bit typed, input rsp_item_t typed_rsp);
    rsp_item_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.mode        <= mode;
    req_bus.block_index <= block_index;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    predicted = apply_request(mode, block_index);
    owed_responses.push_back(typed ? typed_rsp : predicted);
  endtask

  // Bursts of frees of random blocks followed by as many allocations, with some noise.
  task automatic run_random_phase(input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned sent;
    int unsigned burst;
    rsp_item_t   unused_rsp;
    sent          = 0;
    unused_rsp    = '{result_block: '0, status: ST_ALLOC};
    send_gap_pct  = gap_pct;
    rsp_stall_pct = stall_pct;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 6);
      repeat (burst) begin
        send_request(MODE_FREE, INDEX_W'($urandom), 1'b0, unused_rsp);
      end
      repeat (burst) begin
        send_request(MODE_ALLOC, INDEX_W'($urandom), 1'b0, unused_rsp);
      end
      sent += 2 * burst;
      // An unmatched allocation may find the map full; a stray free breaks the pattern.
      if ($urandom_range(0, 7) == 0) begin
        send_request(MODE_ALLOC, INDEX_W'($urandom), 1'b0, unused_rsp);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_request(MODE_FREE, INDEX_W'($urandom), 1'b0, unused_rsp);
        sent++;
      end
    end
  endtask

  // Response side: random stalls, plus one long hold-off on demand.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // Response checker against the oldest owed response.
  always @(posedge clk) begin
    rsp_item_t want;
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (owed_responses.size() == 0) begin
        $error("response with none owed: result_block %0d status %0d",
               rsp_bus.result_block, rsp_bus.status);
        mismatches++;
      end else begin
        want = owed_responses.pop_front();
        if (rsp_bus.result_block !== want.result_block) begin
          $error("result_block expected %0d actual %0d", want.result_block,
                 rsp_bus.result_block);
          mismatches++;
        end
        if (rsp_bus.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, rsp_bus.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    rsp_item_t unused_rsp;
    rsp_item_t typed_rsp;
    unused_rsp          = '{result_block: '0, status: ST_ALLOC};
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.mode        = MODE_ALLOC;
    req_bus.block_index = '0;
    foreach (shadow_map[w]) begin
      shadow_map[w] = '0;
    end
    shadow_map[0] = WORD_BITS'(RESET_WORD0);
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;

    // Directed table without idling.
    rsp_stall_pct = 0;
    send_gap_pct  = 0;
    foreach (directed_rows[i]) begin
      typed_rsp = '{result_block: directed_rows[i].result_block,
                    status: directed_rows[i].status};
      send_request(directed_rows[i].mode, directed_rows[i].block_index,
                   directed_rows[i].typed, typed_rsp);
    end

    // Allocate across the first few words, crossing several word edges.
    repeat (FILL_ITEMS) begin
      send_request(MODE_ALLOC, INDEX_W'($urandom), 1'b0, unused_rsp);
    end

    // Random phases; the first starts with the receiver holding off for a long time.
    hold_off_pending = 1'b1;
    run_random_phase(0, 0);
    run_random_phase(49, 0);
    run_random_phase(0, 49);
    run_random_phase(26, 26);
    req_bus.valid <= 1'b0;

    while (owed_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
